>>> src/first_fit_range_allocator_defines.svh
// Assertion macros for the first-fit range allocator checker.
`ifndef FIRST_FIT_RANGE_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_RANGE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define FFRA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication.
`define FFRA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

>>> src/ffra_pkg.sv
// Shared constants and types for the first-fit range allocator.
`timescale 1ns / 1ps
package ffra_pkg;
  localparam int FREE_SLOTS    = 32;
  localparam int PENDING_SLOTS = 32;
  localparam int FIW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
  localparam int PIW = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
  localparam int FCW = $clog2(FREE_SLOTS + 1);
  localparam int PCW = $clog2(PENDING_SLOTS + 1);

  localparam logic [31:0] CAP_RESET = 32'd1048576;

  localparam logic       CMD_ALLOC = 1'b0;
  localparam logic       CMD_FREE  = 1'b1;
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOSPC  = 2'd1;
  localparam logic [1:0] ST_OVF    = 2'd2;

  // One range entry as stored in the tables
  typedef struct packed {
    logic [31:0] len;
    logic [31:0] start;
  } range_t;
endpackage

>>> src/ffra_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ffra_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> src/first_fit_range_allocator.sv
// First-fit range allocator: sequencer, table RAMs and result register.
// A free is queued on the pending list, after a consolidation pass if it is full;
// an allocate takes the first entry that fits, shifts the later entries down and
// queues any remainder, or on a miss merges pending into the other bank and scans
// again before it falls back to the cursor. The block takes one transaction at a time.
// Reset (rst_n low, synchronous) empties both tables, zeroes the cursor.
`timescale 1ns / 1ps
module first_fit_range_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // range_size[31:0], range_offset[63:32]
  input  logic [0:0]  in_tuser,   // cmd[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // alloc_offset[31:0]
  output logic [1:0]  out_tuser   // status[1:0]
);
  import ffra_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SC_START = 4'd1;
  localparam logic [3:0] S_SC_RD    = 4'd2;
  localparam logic [3:0] S_SC_CHK   = 4'd3;
  localparam logic [3:0] S_SH_RD    = 4'd4;
  localparam logic [3:0] S_SH_WR    = 4'd5;
  localparam logic [3:0] S_TAKE     = 4'd6;
  localparam logic [3:0] S_CS_BEGIN = 4'd7;
  localparam logic [3:0] S_CS_LOOP  = 4'd8;
  localparam logic [3:0] S_FIND_RD  = 4'd9;
  localparam logic [3:0] S_FIND_CHK = 4'd10;
  localparam logic [3:0] S_FREE_RD  = 4'd11;
  localparam logic [3:0] S_FREE_CHK = 4'd12;
  localparam logic [3:0] S_PQ_WR    = 4'd13;
  localparam logic [3:0] S_RESP     = 4'd14;
  localparam logic [3:0] S_MISS     = 4'd15;

  localparam logic RET_QUEUE = 1'b0;
  localparam logic RET_RETRY = 1'b1;

  logic [3:0]  state_r, state_nxt;
  logic [31:0] cap_r, cursor_r, cursor_nxt;
  logic [FCW-1:0] fc_r, fc_nxt, fj_r, fj_nxt, n_r, n_nxt;
  logic [PCW-1:0] pc_r, pc_nxt, picks_r, picks_nxt;
  logic        bank_r, bank_nxt;
  logic [31:0] size_r, size_nxt;
  logic [FIW-1:0] k_r, k_nxt;
  logic [PIW-1:0] pi_r, pi_nxt, pidx_r, pidx_nxt;
  logic        pass2_r, pass2_nxt, ret_r, ret_nxt;
  logic        ovf_r, ovf_nxt, fail_r, fail_nxt;
  logic [31:0] grant_r, grant_nxt;
  range_t      take_r, take_nxt, q_r, q_nxt, p_r, p_nxt, f_r, f_nxt, last_r, last_nxt;
  logic        have_p_r, have_p_nxt, have_f_r, have_f_nxt, found_r, found_nxt;
  logic [PENDING_SLOTS-1:0] used_r, used_nxt;
  logic        ov_r, ov_nxt;
  logic [31:0] od_r, od_nxt;
  logic [1:0]  os_r, os_nxt;

  // RAM ports
  logic           fr_we;
  logic [FIW:0]   fr_waddr, fr_raddr;
  range_t         fr_wdata, fr_rdata;
  logic           pr_we;
  logic [PIW-1:0] pr_waddr, pr_raddr;
  range_t         pr_rdata;

  ffra_ram #(.WIDTH(64), .DEPTH(2 * FREE_SLOTS)) u_free_ram (
    .clk(clk), .we(fr_we), .waddr(fr_waddr), .wdata(fr_wdata),
    .raddr(fr_raddr), .rdata(fr_rdata)
  );

  ffra_ram #(.WIDTH(64), .DEPTH(1 << PIW)) u_pend_ram (
    .clk(clk), .we(pr_we), .waddr(pr_waddr), .wdata(q_r),
    .raddr(pr_raddr), .rdata(pr_rdata)
  );

  // Merge step helpers
  logic        p_rem, f_rem, take_p, join_ok;
  range_t      em;
  logic [32:0] end33, sum33;
  logic [FCW-1:0] n_m1;

  assign p_rem  = picks_r < pc_r;
  assign f_rem  = fj_r < fc_r;
  assign take_p = have_p_r && (!have_f_r || (p_r.start < f_r.start));
  assign em     = take_p ? p_r : f_r;
  assign end33  = {1'b0, last_r.start} + {1'b0, last_r.len};
  assign sum33  = {1'b0, last_r.len} + {1'b0, em.len};
  assign join_ok = (n_r != '0) && (end33 == {1'b0, em.start}) && !sum33[32];
  assign n_m1   = n_r - FCW'(1);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = os_r;

  always_comb begin
    logic [32:0] bump;
    state_nxt = state_r;
    cursor_nxt = cursor_r; fc_nxt = fc_r; fj_nxt = fj_r; n_nxt = n_r;
    pc_nxt = pc_r; picks_nxt = picks_r; bank_nxt = bank_r;
    size_nxt = size_r; k_nxt = k_r;
    pi_nxt = pi_r; pidx_nxt = pidx_r; pass2_nxt = pass2_r; ret_nxt = ret_r;
    ovf_nxt = ovf_r; fail_nxt = fail_r; grant_nxt = grant_r;
    take_nxt = take_r; q_nxt = q_r; p_nxt = p_r; f_nxt = f_r; last_nxt = last_r;
    have_p_nxt = have_p_r; have_f_nxt = have_f_r; found_nxt = found_r;
    used_nxt = used_r; ov_nxt = ov_r; od_nxt = od_r; os_nxt = os_r;
    fr_we = 1'b0; fr_waddr = {bank_r, k_r}; fr_wdata = fr_rdata;
    fr_raddr = {bank_r, k_r};
    pr_we = 1'b0; pr_waddr = pc_r[PIW-1:0]; pr_raddr = pi_r;
    bump = {1'b0, cursor_r} + {1'b0, size_r};

    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          size_nxt  = in_tdata[31:0];
          ovf_nxt   = 1'b0;
          fail_nxt  = 1'b0;
          grant_nxt = '0;
          pass2_nxt = 1'b0;
          if (in_tuser[0] == CMD_FREE) begin
            q_nxt = '{len: in_tdata[31:0], start: in_tdata[63:32]};
            ret_nxt = RET_QUEUE;
            state_nxt = (pc_r == PCW'(PENDING_SLOTS)) ? S_CS_BEGIN : S_PQ_WR;
          end else begin
            state_nxt = S_SC_START;
          end
        end
      end
      // first-fit scan of the current bank
      S_SC_START: begin
        k_nxt = '0;
        state_nxt = (fc_r == '0) ? S_MISS : S_SC_RD;
      end
      S_SC_RD: begin
        fr_raddr = {bank_r, k_r};
        state_nxt = S_SC_CHK;
      end
      S_SC_CHK: begin
        if (fr_rdata.len >= size_r) begin
          take_nxt = fr_rdata;
          state_nxt = ((FCW'(k_r) + FCW'(1)) < fc_r) ? S_SH_RD : S_TAKE;
        end else if ((FCW'(k_r) + FCW'(1)) == fc_r) begin
          state_nxt = S_MISS;
        end else begin
          k_nxt = k_r + FIW'(1);
          state_nxt = S_SC_RD;
        end
      end
      // close the gap left by the taken entry
      S_SH_RD: begin
        fr_raddr = {bank_r, k_r + FIW'(1)};
        state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        fr_we = 1'b1;
        fr_waddr = {bank_r, k_r};
        fr_wdata = fr_rdata;
        k_nxt = k_r + FIW'(1);
        state_nxt = ((FCW'(k_r) + FCW'(2)) < fc_r) ? S_SH_RD : S_TAKE;
      end
      S_TAKE: begin
        fc_nxt = fc_r - FCW'(1);
        grant_nxt = take_r.start;
        if (take_r.len > size_r) begin
          q_nxt = '{len: take_r.len - size_r, start: take_r.start + size_r};
          ret_nxt = RET_QUEUE;
          state_nxt = (pc_r == PCW'(PENDING_SLOTS)) ? S_CS_BEGIN : S_PQ_WR;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_MISS: begin
        if (!pass2_r) begin
          ret_nxt = RET_RETRY;
          state_nxt = S_CS_BEGIN;
        end else begin
          if (bump <= {1'b0, cap_r}) begin
            grant_nxt = cursor_r;
            cursor_nxt = bump[31:0];
          end else begin
            grant_nxt = '0;
            fail_nxt = 1'b1;
          end
          state_nxt = S_RESP;
        end
      end
      // consolidation: ascending merge of pending and free entries into the other bank
      S_CS_BEGIN: begin
        picks_nxt = '0; fj_nxt = '0; n_nxt = '0;
        have_p_nxt = 1'b0; have_f_nxt = 1'b0; used_nxt = '0;
        if (pc_r == '0) begin
          if (ret_r == RET_RETRY) begin
            pass2_nxt = 1'b1;
            state_nxt = S_SC_START;
          end else begin
            state_nxt = S_PQ_WR;
          end
        end else begin
          state_nxt = S_CS_LOOP;
        end
      end
      S_CS_LOOP: begin
        if (p_rem && !have_p_r) begin
          pi_nxt = '0;
          found_nxt = 1'b0;
          state_nxt = S_FIND_RD;
        end else if (f_rem && !have_f_r) begin
          state_nxt = S_FREE_RD;
        end else if (!p_rem && !f_rem) begin
          bank_nxt = ~bank_r;
          fc_nxt = n_r;
          pc_nxt = '0;
          if (ret_r == RET_RETRY) begin
            pass2_nxt = 1'b1;
            state_nxt = S_SC_START;
          end else begin
            state_nxt = S_PQ_WR;
          end
        end else begin
          if (take_p) begin
            used_nxt[pidx_r] = 1'b1;
            picks_nxt = picks_r + PCW'(1);
            have_p_nxt = 1'b0;
          end else begin
            fj_nxt = fj_r + FCW'(1);
            have_f_nxt = 1'b0;
          end
          // emit: drop empty, join adjacent, else append or overflow
          if (em.len != '0) begin
            if (join_ok) begin
              last_nxt.len = sum33[31:0];
              fr_we = 1'b1;
              fr_waddr = {~bank_r, n_m1[FIW-1:0]};
              fr_wdata = '{len: sum33[31:0], start: last_r.start};
            end else if (n_r < FCW'(FREE_SLOTS)) begin
              last_nxt = em;
              fr_we = 1'b1;
              fr_waddr = {~bank_r, n_r[FIW-1:0]};
              fr_wdata = em;
              n_nxt = n_r + FCW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
        end
      end
      S_FIND_RD: begin
        pr_raddr = pi_r;
        state_nxt = S_FIND_CHK;
      end
      S_FIND_CHK: begin
        if (!used_r[pi_r] && (!found_r || (pr_rdata.start < p_r.start))) begin
          p_nxt = pr_rdata;
          pidx_nxt = pi_r;
          found_nxt = 1'b1;
        end
        if ((PCW'(pi_r) + PCW'(1)) == pc_r) begin
          have_p_nxt = 1'b1;
          state_nxt = S_CS_LOOP;
        end else begin
          pi_nxt = pi_r + PIW'(1);
          state_nxt = S_FIND_RD;
        end
      end
      S_FREE_RD: begin
        fr_raddr = {bank_r, fj_r[FIW-1:0]};
        state_nxt = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        f_nxt = fr_rdata;
        have_f_nxt = 1'b1;
        state_nxt = S_CS_LOOP;
      end
      S_PQ_WR: begin
        pr_we = 1'b1;
        pr_waddr = pc_r[PIW-1:0];
        pc_nxt = pc_r + PCW'(1);
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1;
          od_nxt = grant_r;
          os_nxt = fail_r ? ST_NOSPC : (ovf_r ? ST_OVF : ST_OK);
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cap_r    <= CAP_RESET;
      cursor_r <= '0;
      fc_r     <= '0;
      pc_r     <= '0;
      bank_r   <= 1'b0;
      ov_r     <= 1'b0;
      used_r   <= '0;
      have_p_r <= 1'b0;
      have_f_r <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      cursor_r <= cursor_nxt;
      fc_r     <= fc_nxt;
      pc_r     <= pc_nxt;
      bank_r   <= bank_nxt;
      ov_r     <= ov_nxt;
      used_r   <= used_nxt;
      have_p_r <= have_p_nxt;
      have_f_r <= have_f_nxt;
      found_r  <= found_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    fj_r <= fj_nxt; n_r <= n_nxt; picks_r <= picks_nxt;
    size_r <= size_nxt; k_r <= k_nxt;
    pi_r <= pi_nxt; pidx_r <= pidx_nxt; pass2_r <= pass2_nxt; ret_r <= ret_nxt;
    ovf_r <= ovf_nxt; fail_r <= fail_nxt; grant_r <= grant_nxt;
    take_r <= take_nxt; q_r <= q_nxt; p_r <= p_nxt; f_r <= f_nxt;
    last_r <= last_nxt; od_r <= od_nxt; os_r <= os_nxt;
  end
endmodule

>>> src/ffra_checker.sv
// Port-level checker for the first-fit range allocator, bound to the top.
`timescale 1ns / 1ps
`include "first_fit_range_allocator_defines.svh"
module ffra_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import ffra_pkg::*;

  // status code three is never produced
  `FFRA_ASSERT_NOW(a_status_code, out_tvalid, out_tuser != 2'd3)
  // a failed allocate grants no offset
  `FFRA_ASSERT_NOW(a_fail_zero, out_tvalid && (out_tuser == ST_NOSPC), out_tdata == '0)
  // the block is busy in the cycle after taking a transaction
  `FFRA_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  // a stalled result stays offered
  `FFRA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
endmodule

bind first_fit_range_allocator ffra_checker u_ffra_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);

>>> dv/tb_top.sv
// Testbench for the first-fit range allocator: stream driver, result monitor, allocator model.
`timescale 1ns / 1ps
module tb_top;
  import ffra_pkg::*;

  localparam int WATCHDOG_LIMIT = 60000;

  // Kinds of entries in the stimulus queue
  typedef enum logic [2:0] {
    K_RAW, K_ALLOC, K_LIVE_FREE, K_NOISE_FREE, K_CFG, K_DRAIN
  } job_kind_t;

  typedef struct {
    job_kind_t   kind;
    logic        cmd;
    logic [31:0] size;
    logic [31:0] offs;
  } job_t;

  typedef struct {
    logic [31:0] grant;
    logic [1:0]  status;
  } grant_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // range_size[31:0], range_offset[63:32]
  logic [0:0]  in_tuser = '0;   // cmd[0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // alloc_offset[31:0]
  logic [1:0]  out_tuser;       // status[1:0]

  first_fit_range_allocator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  job_t   job_q[$];
  grant_t grant_exp_q[$];
  logic [31:0] live_off[$];
  logic [31:0] live_len[$];
  int errors = 0;
  bit driver_busy = 1'b0;
  int idle_cycles = 0;

  // ---------------------------------------------------------------------
  // Allocator model
  // ---------------------------------------------------------------------
  logic [31:0] m_cap;
  logic [31:0] m_free_s[FREE_SLOTS];
  logic [31:0] m_free_l[FREE_SLOTS];
  int          m_free_n;
  logic [31:0] m_pend_s[PENDING_SLOTS];
  logic [31:0] m_pend_l[PENDING_SLOTS];
  int          m_pend_n;
  logic [31:0] m_cursor;
  bit          m_dropped;
  logic [31:0] m_new_s[FREE_SLOTS];
  logic [31:0] m_new_l[FREE_SLOTS];
  int          m_new_n;

  task automatic model_reset();
    m_cap = CAP_RESET;
    m_free_n = 0;
    m_pend_n = 0;
    m_cursor = '0;
  endtask

  // Append a range to the rebuilt table, joining with the previous one if adjacent
  task automatic append_range(logic [31:0] s, logic [31:0] l);
    logic [32:0] prev_end;
    logic [32:0] sum;
    if (l == 0) return;
    if (m_new_n > 0) begin
      prev_end = {1'b0, m_new_s[m_new_n-1]} + {1'b0, m_new_l[m_new_n-1]};
      sum = {1'b0, m_new_l[m_new_n-1]} + {1'b0, l};
      if (prev_end == {1'b0, s} && !sum[32]) begin
        m_new_l[m_new_n-1] = sum[31:0];
        return;
      end
    end
    if (m_new_n < FREE_SLOTS) begin
      m_new_s[m_new_n] = s;
      m_new_l[m_new_n] = l;
      m_new_n++;
    end else begin
      m_dropped = 1'b1;
    end
  endtask

  // Stable sort of the pending frees, then merge into the free table
  task automatic merge_pending();
    int i, j;
    logic [31:0] s, l;
    if (m_pend_n == 0) return;
    for (i = 1; i < m_pend_n; i++) begin
      s = m_pend_s[i];
      l = m_pend_l[i];
      j = i;
      while (j > 0 && m_pend_s[j-1] > s) begin
        m_pend_s[j] = m_pend_s[j-1];
        m_pend_l[j] = m_pend_l[j-1];
        j--;
      end
      m_pend_s[j] = s;
      m_pend_l[j] = l;
    end
    m_new_n = 0;
    i = 0;
    j = 0;
    while (i < m_pend_n || j < m_free_n) begin
      if (i < m_pend_n && (j >= m_free_n || m_pend_s[i] < m_free_s[j])) begin
        append_range(m_pend_s[i], m_pend_l[i]);
        i++;
      end else begin
        append_range(m_free_s[j], m_free_l[j]);
        j++;
      end
    end
    for (i = 0; i < m_new_n; i++) begin
      m_free_s[i] = m_new_s[i];
      m_free_l[i] = m_new_l[i];
    end
    m_free_n = m_new_n;
    m_pend_n = 0;
  endtask

  task automatic push_pending(logic [31:0] s, logic [31:0] l);
    if (m_pend_n >= PENDING_SLOTS) merge_pending();
    m_pend_s[m_pend_n] = s;
    m_pend_l[m_pend_n] = l;
    m_pend_n++;
  endtask

  task automatic grab_first_fit(logic [31:0] size, output bit ok, output logic [31:0] off);
    int k, m;
    logic [31:0] s, l;
    ok = 1'b0;
    off = '0;
    for (k = 0; k < m_free_n; k++) begin
      if (m_free_l[k] >= size) begin
        s = m_free_s[k];
        l = m_free_l[k];
        for (m = k; m + 1 < m_free_n; m++) begin
          m_free_s[m] = m_free_s[m+1];
          m_free_l[m] = m_free_l[m+1];
        end
        m_free_n--;
        if (l > size) push_pending(s + size, l - size);
        off = s;
        ok = 1'b1;
        return;
      end
    end
  endtask

  // Expected result of one accepted transaction
  task automatic predict_grant(logic cmd, logic [31:0] size, logic [31:0] offs,
                               output grant_t res);
    bit ok;
    logic [31:0] g;
    m_dropped = 1'b0;
    res.grant = '0;
    res.status = ST_OK;
    if (cmd == CMD_FREE) begin
      push_pending(offs, size);
    end else begin
      grab_first_fit(size, ok, g);
      if (!ok) begin
        merge_pending();
        grab_first_fit(size, ok, g);
      end
      if (!ok && ({1'b0, m_cursor} + {1'b0, size} <= {1'b0, m_cap})) begin
        g = m_cursor;
        m_cursor = m_cursor + size;
        ok = 1'b1;
      end
      if (ok) begin
        res.grant = g;
        if (size != 0) begin
          live_off.push_back(g);
          live_len.push_back(size);
        end
      end else begin
        res.status = ST_NOSPC;
      end
    end
    if (res.status == ST_OK && m_dropped) res.status = ST_OVF;
  endtask

  // ---------------------------------------------------------------------
  // Driver
  // ---------------------------------------------------------------------
  job_t cur_job;
  int   gap_left = 0;
  int   settle = 0;
  int   burst_left = 0;

  function automatic logic [31:0] rand_alloc_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 64);
    if (r < 80) return $urandom_range(0, 4096);
    if (r < 90) return 32'd0;
    return $urandom;
  endfunction

  always @(posedge clk) begin
    logic   nxt_valid;
    logic   nxt_cfg;
    grant_t res;
    int     pick;
    nxt_valid = in_tvalid;
    nxt_cfg = 1'b0;
    if (!rst_n) begin
      nxt_valid = 1'b0;
      model_reset();
    end else begin
      // accepted transaction: predict and queue its result
      if (in_tvalid && in_tready) begin
        predict_grant(cur_job.cmd, cur_job.size, cur_job.offs, res);
        grant_exp_q.push_back(res);
        driver_busy = 1'b0;
        nxt_valid = 1'b0;
      end
      if (!driver_busy && job_q.size() > 0) begin
        if (job_q[0].kind == K_CFG || job_q[0].kind == K_DRAIN) begin
          // wait until every result is back and the block has settled
          if (grant_exp_q.size() == 0) settle++;
          else settle = 0;
          if (settle >= 8) begin
            if (job_q[0].kind == K_CFG) begin
              nxt_cfg = 1'b1;
              cfg_wr_data <= job_q[0].size;
              m_cap = job_q[0].size;
            end
            void'(job_q.pop_front());
            settle = 0;
          end
        end else if (gap_left > 0) begin
          gap_left--;
        end else begin
          cur_job = job_q.pop_front();
          case (cur_job.kind)
            K_ALLOC: begin
              cur_job.cmd = CMD_ALLOC;
              cur_job.size = rand_alloc_size();
              cur_job.offs = $urandom;
            end
            K_LIVE_FREE: begin
              cur_job.cmd = CMD_FREE;
              if (live_off.size() > 0) begin
                pick = $urandom_range(0, live_off.size() - 1);
                cur_job.offs = live_off[pick];
                cur_job.size = live_len[pick];
                live_off.delete(pick);
                live_len.delete(pick);
              end else begin
                cur_job.offs = $urandom_range(0, 100000);
                cur_job.size = $urandom_range(1, 64);
              end
            end
            K_NOISE_FREE: begin
              cur_job.cmd = CMD_FREE;
              cur_job.offs = $urandom;
              cur_job.size = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 64);
            end
            default: ;
          endcase
          in_tdata <= {cur_job.offs, cur_job.size};
          in_tuser <= cur_job.cmd;
          nxt_valid = 1'b1;
          driver_busy = 1'b1;
          // gap before the next transaction; some stretches have none
          if (burst_left > 0) begin
            burst_left--;
            gap_left = 0;
          end else if ($urandom_range(0, 29) == 0) begin
            burst_left = $urandom_range(10, 40);
            gap_left = 0;
          end else begin
            gap_left = $urandom_range(0, 16);
          end
        end
      end
    end
    in_tvalid <= nxt_valid;
    cfg_wr_en <= nxt_cfg;
  end

  // ---------------------------------------------------------------------
  // Monitor
  // ---------------------------------------------------------------------
  int  rx_count = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got 0x%08h want 0x%08h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    grant_t want;
    logic   nxt_ready;
    nxt_ready = out_tready;
    if (!rst_n) begin
      nxt_ready = 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        rx_count++;
        if (grant_exp_q.size() == 0) begin
          report_mismatch("unexpected transaction, offset", out_tdata, '0);
        end else begin
          want = grant_exp_q.pop_front();
          if (out_tdata !== want.grant) report_mismatch("alloc_offset", out_tdata, want.grant);
          if (out_tuser !== want.status)
            report_mismatch("status", {30'd0, out_tuser}, {30'd0, want.status});
        end
        nxt_ready = 1'b0;
        stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        // one long hold-off so the block backs up
        if (rx_count == 400 && !hold_done) begin
          hold_done = 1'b1;
          hold_left = 600;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
    end
    out_tready <= nxt_ready;
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", grant_exp_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  function automatic job_t mk(job_kind_t k, logic cmd = CMD_ALLOC, logic [31:0] size = '0,
                              logic [31:0] offs = '0);
    job_t j;
    j.kind = k;
    j.cmd = cmd;
    j.size = size;
    j.offs = offs;
    return j;
  endfunction

  task automatic add_random_phase(int count);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 50) job_q.push_back(mk(K_ALLOC));
      else if (r < 85) job_q.push_back(mk(K_LIVE_FREE));
      else job_q.push_back(mk(K_NOISE_FREE));
      // sender pause until all results are back
      if (n == count / 2 && $urandom_range(0, 1) == 0) job_q.push_back(mk(K_DRAIN));
    end
  endtask

  initial begin
    // directed: zero-size allocate on empty table returns the cursor
    job_q.push_back(mk(K_RAW, CMD_ALLOC, 32'd0));
    job_q.push_back(mk(K_RAW, CMD_ALLOC, 32'd100));
    job_q.push_back(mk(K_RAW, CMD_ALLOC, 32'hFFFF_FFFF));           // no space
    job_q.push_back(mk(K_RAW, CMD_FREE, 32'd0, 32'd50));             // zero-size free
    job_q.push_back(mk(K_RAW, CMD_FREE, 32'd10, 32'd0));
    job_q.push_back(mk(K_RAW, CMD_FREE, 32'd10, 32'd10));            // adjacent, joins
    job_q.push_back(mk(K_RAW, CMD_FREE, 32'd10, 32'd0));             // equal starts
    job_q.push_back(mk(K_RAW, CMD_ALLOC, 32'd5000));                 // forces merge
    job_q.push_back(mk(K_RAW, CMD_ALLOC, 32'd0));                    // whole entry requeued
    job_q.push_back(mk(K_RAW, CMD_ALLOC, 32'd7));                    // remainder queued
    job_q.push_back(mk(K_RAW, CMD_FREE, 32'h10, 32'hFFFF_FFF0));     // ends at top, no wrap
    job_q.push_back(mk(K_RAW, CMD_FREE, 32'hFFFF_FFFF, 32'h0));      // spans offsets 0 to 0xFFFF_FFFE
    job_q.push_back(mk(K_RAW, CMD_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    job_q.push_back(mk(K_RAW, CMD_ALLOC, 32'hFFFF_FFFF));
    job_q.push_back(mk(K_RAW, CMD_ALLOC, 32'hFFFF_FFFF));
    job_q.push_back(mk(K_RAW, CMD_ALLOC, 32'h8000_0000));
    // scattered frees to fill pending list and overflow the free table
    for (int n = 0; n < 36; n++)
      job_q.push_back(mk(K_RAW, CMD_FREE, 32'd1, 32'h4000_0000 + 32'(n) * 32'd4));
    job_q.push_back(mk(K_RAW, CMD_ALLOC, 32'h7FFF_FFFF));
    job_q.push_back(mk(K_RAW, CMD_ALLOC, 32'd2));

    // random phases over several capacity settings
    job_q.push_back(mk(K_CFG, CMD_ALLOC, 32'd0));
    add_random_phase(290);
    job_q.push_back(mk(K_CFG, CMD_ALLOC, 32'hFFFF_FFFF));
    add_random_phase(300);
    job_q.push_back(mk(K_CFG, CMD_ALLOC, 32'd2048));
    add_random_phase(300);
    job_q.push_back(mk(K_CFG, CMD_ALLOC, $urandom));
    add_random_phase(300);
    job_q.push_back(mk(K_CFG, CMD_ALLOC, CAP_RESET));
    add_random_phase(300);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (job_q.size() > 0 || driver_busy || grant_exp_q.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
